// File: design/ehs_pkg.sv
// Shared constants and types for the explicit 1D heat stencil block.
// Used by ehs_ctrl, ehs_dp and explicit_heat_stencil_1d; no dependencies.
package ehs_pkg;

  // Grid and sample sizing
  localparam int MAX_POINTS  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int ADDR_BITS   = $clog2(MAX_POINTS);
  localparam int PC_BITS     = $clog2(MAX_POINTS + 1);

  // Configuration register widths
  localparam int STEP_BITS      = 16;
  localparam int ALPHA_BITS     = 16;
  localparam int ALPHA_FRAC     = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA       = 2'd2;

  // Configuration reset values
  localparam logic [PC_BITS-1:0]    POINT_COUNT_RESET = PC_BITS'(10);
  localparam logic [STEP_BITS-1:0]  STEP_COUNT_RESET  = STEP_BITS'(199);
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET       = ALPHA_BITS'(26676);

  // Stencil arithmetic widths
  localparam int LAP_BITS  = SAMPLE_BITS + 2;
  localparam int PROD_BITS = LAP_BITS + ALPHA_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS - ALPHA_FRAC + 1;

  // Grid store write data source
  typedef enum logic {
    WSEL_INPUT,
    WSEL_UPDATE
  } wsel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                 ram_we;
    wsel_t                wsel;
    logic [ADDR_BITS-1:0] waddr;
    logic [ADDR_BITS-1:0] raddr;
    logic                 cap_left;
    logic                 cap_p;
    logic                 cap_right;
    logic                 cap_prod;
    logic                 advance;
    logic                 cap_out;
  } ehs_cmd_t;

endpackage

// File: design/ehs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ehs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ehs_dp.sv
// Datapath of the heat stencil: grid store, stencil window, multiply and saturate.
// Depends on ehs_pkg and ehs_ram; driven by commands from ehs_ctrl.
module ehs_dp
  import ehs_pkg::*;
(
  input  logic                          clk,
  input  ehs_cmd_t                      cmd,
  input  logic [ALPHA_BITS-1:0]         alpha,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] rdata;
  logic signed [SAMPLE_BITS-1:0] wdata;
  logic signed [SAMPLE_BITS-1:0] left;
  logic signed [SAMPLE_BITS-1:0] p;
  logic signed [SAMPLE_BITS-1:0] right;
  logic signed [LAP_BITS-1:0]    lap;
  logic signed [LAP_BITS-1:0]    lap_next;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   prod_next;
  logic signed [ALPHA_BITS:0]    alpha_s;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SAMPLE_BITS-1:0] upd;

  ehs_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_POINTS)
  ) u_grid (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(cmd.waddr),
    .wdata(wdata),
    .raddr(cmd.raddr),
    .rdata(rdata)
  );

  // Laplacian from the window, right neighbor straight from the store
  always_comb begin
    lap_next = {{2{left[SAMPLE_BITS-1]}}, left}
             - {p[SAMPLE_BITS-1], p, 1'b0}
             + {{2{rdata[SAMPLE_BITS-1]}}, rdata};
    alpha_s   = {1'b0, alpha};
    prod_next = lap * alpha_s;
  end

  // Floor shift of the product, add to center, saturate
  always_comb begin
    sum = {{(SUM_BITS-SAMPLE_BITS){p[SAMPLE_BITS-1]}}, p}
        + {prod[PROD_BITS-1], prod[PROD_BITS-1:ALPHA_FRAC]};
    if (sum[SUM_BITS-1:SAMPLE_BITS-1] == {(SUM_BITS-SAMPLE_BITS+1){1'b0}} ||
        sum[SUM_BITS-1:SAMPLE_BITS-1] == {(SUM_BITS-SAMPLE_BITS+1){1'b1}}) begin
      upd = sum[SAMPLE_BITS-1:0];
    end else if (sum[SUM_BITS-1]) begin
      upd = SAMPLE_MIN;
    end else begin
      upd = SAMPLE_MAX;
    end
    wdata = (cmd.wsel == WSEL_UPDATE) ? upd : sample_in;
  end

  // Window and pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.cap_left) begin
      left <= rdata;
    end
    if (cmd.cap_p) begin
      p <= rdata;
    end
    if (cmd.cap_right) begin
      right <= rdata;
      lap   <= lap_next;
    end
    if (cmd.cap_prod) begin
      prod <= prod_next;
    end
    if (cmd.advance) begin
      left <= p;
      p    <= right;
    end
    if (cmd.cap_out) begin
      sample_out <= rdata;
    end
  end

endmodule

// File: design/ehs_ctrl.sv
// Controller of the heat stencil: load sequencing, time step sweeps, result output.
// Depends on ehs_pkg; commands ehs_dp.
module ehs_ctrl
  import ehs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PC_BITS-1:0]   point_count,
  input  logic [STEP_BITS-1:0] step_count,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 last_out,
  output ehs_cmd_t             cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_L,
    S_RD_P,
    S_FIRST,
    S_RD_R,
    S_LAP,
    S_MUL,
    S_WR,
    S_O_RD,
    S_O_LD,
    S_O_WAIT
  } state_t;

  state_t               state;
  logic [PC_BITS-1:0]   load_pos;
  logic [ADDR_BITS-1:0] idx;
  logic [STEP_BITS-1:0] steps;

  logic [PC_BITS-1:0]   n_eff;
  logic [PC_BITS-1:0]   pos;
  logic                 in_acc;
  logic                 run_needed;
  logic                 last_pt;
  logic                 last_res;

  // Effective grid size and load position
  always_comb begin
    if (point_count == '0) begin
      n_eff = PC_BITS'(1);
    end else if (point_count > PC_BITS'(MAX_POINTS)) begin
      n_eff = PC_BITS'(MAX_POINTS);
    end else begin
      n_eff = point_count;
    end
    pos        = (load_pos >= n_eff) ? n_eff - PC_BITS'(1) : load_pos;
    in_stall   = rst || (state != S_IDLE);
    in_acc     = in_valid && !in_stall;
    run_needed = (n_eff >= PC_BITS'(3)) && (step_count != '0);
    last_pt    = (PC_BITS'(idx) + PC_BITS'(2)) == n_eff;
    last_res   = (PC_BITS'(idx) + PC_BITS'(1)) == n_eff;
  end

  // Datapath commands per state
  always_comb begin
    cmd       = '0;
    cmd.wsel  = WSEL_INPUT;
    cmd.waddr = idx;
    cmd.raddr = idx;
    unique case (state)
      S_IDLE: begin
        cmd.ram_we = in_acc;
        cmd.waddr  = pos[ADDR_BITS-1:0];
      end
      S_RD_L: begin
        cmd.raddr = '0;
      end
      S_RD_P: begin
        cmd.raddr    = ADDR_BITS'(1);
        cmd.cap_left = 1'b1;
      end
      S_FIRST: begin
        cmd.raddr = idx + ADDR_BITS'(1);
        cmd.cap_p = 1'b1;
      end
      S_RD_R: begin
        cmd.raddr = idx + ADDR_BITS'(1);
      end
      S_LAP: begin
        cmd.cap_right = 1'b1;
      end
      S_MUL: begin
        cmd.cap_prod = 1'b1;
      end
      S_WR: begin
        cmd.ram_we  = 1'b1;
        cmd.wsel    = WSEL_UPDATE;
        cmd.advance = 1'b1;
      end
      S_O_RD: begin
        cmd.raddr = idx;
      end
      S_O_LD: begin
        cmd.cap_out = 1'b1;
      end
      S_O_WAIT: begin
        cmd.raddr = idx;
      end
      default: begin
        cmd.raddr = idx;
      end
    endcase
  end

  // State, counters and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      load_pos  <= '0;
      idx       <= '0;
      steps     <= '0;
      out_valid <= 1'b0;
      last_out  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (pos + PC_BITS'(1) < n_eff) begin
              load_pos <= pos + PC_BITS'(1);
            end else begin
              load_pos <= '0;
              steps    <= '0;
              if (run_needed) begin
                idx   <= ADDR_BITS'(1);
                state <= S_RD_L;
              end else begin
                idx   <= '0;
                state <= S_O_RD;
              end
            end
          end
        end
        S_RD_L:  state <= S_RD_P;
        S_RD_P:  state <= S_FIRST;
        S_FIRST: state <= S_LAP;
        S_RD_R:  state <= S_LAP;
        S_LAP:   state <= S_MUL;
        S_MUL:   state <= S_WR;
        S_WR: begin
          if (last_pt) begin
            if (steps == step_count - STEP_BITS'(1)) begin
              steps <= '0;
              idx   <= '0;
              state <= S_O_RD;
            end else begin
              steps <= steps + STEP_BITS'(1);
              idx   <= ADDR_BITS'(1);
              state <= S_RD_L;
            end
          end else begin
            idx   <= idx + ADDR_BITS'(1);
            state <= S_RD_R;
          end
        end
        S_O_RD: state <= S_O_LD;
        S_O_LD: begin
          out_valid <= 1'b1;
          last_out  <= last_res;
          state     <= S_O_WAIT;
        end
        S_O_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_out) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + ADDR_BITS'(1);
              state <= S_O_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/explicit_heat_stencil_1d.sv
// Top level of the explicit 1D heat stencil: configuration registers and wiring.
// Depends on ehs_pkg, ehs_ctrl, ehs_dp and ehs_ram.
//
// Usage:
//   Configuration: cfg_write with cfg_index selects point_count (0), step_count (1)
//   or alpha (2); write only while the block is idle.
//   Input channel: in_valid / in_stall carry one Q16.16 sample per item, grid
//   point 0 first. Items that do not complete the profile are taken back to back.
//   The item that completes the profile starts step_count time steps. Each step
//   updates the N-2 interior points of N points in turn, one stencil update at a time through
//   the single grid store read port and the shared multiplier.
//   Output channel: out_valid / out_stall return the N final samples in grid order,
//   last_out marking the final one; each result is read back from the grid store.
//   A stalled result holds its value until taken. in_stall stays high from the
//   completing item until the last result is taken.
//   Reset: rst (synchronous) restores the register defaults (10, 199, 26676),
//   restarts loading at point 0 and drops any run in progress. The grid store
//   needs no clearing.
module explicit_heat_stencil_1d
  import ehs_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          last_out
);

  logic [PC_BITS-1:0]    point_count;
  logic [STEP_BITS-1:0]  step_count;
  logic [ALPHA_BITS-1:0] alpha;
  ehs_cmd_t              cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RESET;
      step_count  <= STEP_COUNT_RESET;
      alpha       <= ALPHA_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_POINT_COUNT: point_count <= cfg_data[PC_BITS-1:0];
        CFG_STEP_COUNT:  step_count  <= cfg_data[STEP_BITS-1:0];
        CFG_ALPHA:       alpha       <= cfg_data[ALPHA_BITS-1:0];
        default: begin
          point_count <= point_count;
        end
      endcase
    end
  end

  ehs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .point_count(point_count),
    .step_count (step_count),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .last_out   (last_out),
    .cmd        (cmd)
  );

  ehs_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .alpha     (alpha),
    .sample_in (sample_in),
    .sample_out(sample_out)
  );

endmodule

// File: verif/ehs_profile_checker.sv
// Checker for the explicit 1D heat stencil: watches the register port and both channels,
// predicts every final profile and compares each result with it.
// Depends on ehs_pkg.
module ehs_profile_checker
  import ehs_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          last_out,
  output int                            failures,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  // keep the log readable when the block is badly off
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    int                          point;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                        last;
  } profile_point_t;

  // predictor copy of registers and state
  logic [PC_BITS-1:0]    points_reg;
  logic [STEP_BITS-1:0]  steps_reg;
  logic [ALPHA_BITS-1:0] alpha_reg;
  longint                grid [MAX_POINTS];
  int                    load_pos;
  profile_point_t        final_profile_q [$];

  task automatic report_mismatch(input string what);
    if (failures < PRINT_LIMIT)
      $display("[%0t] profile check: %s", $time, what);
    failures++;
  endtask

  function automatic longint clamp_sample(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // FTCS time steps over the held profile; both ends stay fixed
  function automatic void diffuse(input int n);
    longint prev, centre, lap, delta;
    for (int s = 0; s < int'(steps_reg); s++) begin
      prev = grid[0];
      for (int j = 1; j < n - 1; j++) begin
        centre  = grid[j];
        lap     = prev - 2 * centre + grid[j + 1];
        delta   = (lap * longint'(alpha_reg)) >>> ALPHA_FRAC;
        grid[j] = clamp_sample(centre + delta);
        prev    = centre;
      end
    end
  endfunction

  // store one sample; the item that completes the profile yields the whole result set
  function automatic void load_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int n, pos;
    profile_point_t pt;
    n = (points_reg == 0) ? 1 : ((points_reg > MAX_POINTS) ? MAX_POINTS : int'(points_reg));
    pos = (load_pos >= n) ? n - 1 : load_pos;
    grid[pos] = longint'(s);
    if (pos + 1 < n) begin
      load_pos = pos + 1;
    end else begin
      load_pos = 0;
      diffuse(n);
      for (int k = 0; k < n; k++) begin
        pt.point  = k;
        pt.sample = grid[k][SAMPLE_BITS-1:0];
        pt.last   = (k == n - 1);
        final_profile_q.push_back(pt);
      end
    end
  endfunction

  always @(posedge clk) begin
    profile_point_t want;
    if (rst) begin
      points_reg = POINT_COUNT_RESET;
      steps_reg  = STEP_COUNT_RESET;
      alpha_reg  = ALPHA_RESET;
      load_pos   = 0;
      failures   = 0;
      final_profile_q.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          CFG_POINT_COUNT: points_reg = cfg_data[PC_BITS-1:0];
          CFG_STEP_COUNT:  steps_reg  = cfg_data[STEP_BITS-1:0];
          CFG_ALPHA:       alpha_reg  = cfg_data[ALPHA_BITS-1:0];
          default: ;
        endcase
      end
      // accepted input item
      if (in_valid && !in_stall)
        load_sample(sample_in);
      // accepted result item
      if (out_valid && !out_stall) begin
        if (final_profile_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result sample=%0d last=%0b",
                                    sample_out, last_out));
        end else begin
          want = final_profile_q.pop_front();
          if (sample_out !== want.sample)
            report_mismatch($sformatf("point %0d sample_out %0d, expected %0d",
                                      want.point, sample_out, want.sample));
          if (last_out !== want.last)
            report_mismatch($sformatf("point %0d last_out %0b, expected %0b",
                                      want.point, last_out, want.last));
        end
      end
    end
    pending <= final_profile_q.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the explicit 1D heat stencil testbench: clock, reset, register writes,
// sample loads with random idling and result stalls, and the verdict.
// Depends on ehs_pkg, explicit_heat_stencil_1d and ehs_profile_checker.
module testbench
  import ehs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 32;
  localparam int RANDOM_ITEMS  = 300;
  localparam int CALM_ITEMS    = 40;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last_out;
  int                            failures;
  int                            pending;

  bit calm;
  int items_sent;

  explicit_heat_stencil_1d DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .sample_in,
    .out_valid, .out_stall, .sample_out, .last_out
  );

  ehs_profile_checker profile_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .sample_in,
    .out_valid, .out_stall, .sample_out, .last_out,
    .failures, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("explicit_heat_stencil_1d verification failed");
    $finish;
  end

  // result side: quiet stretches and stall bursts, none once calm
  initial begin
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (calm || $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b0;
        repeat (calm ? 1 : $urandom_range(1, 60)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  function automatic int effective_points(input int pc);
    if (pc == 0) return 1;
    if (pc > MAX_POINTS) return MAX_POINTS;
    return pc;
  endfunction

  // leaves cfg_write high; the caller lowers it
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_BITS-1:0] pc, st, al);
    write_reg(CFG_POINT_COUNT, pc);
    write_reg(CFG_STEP_COUNT, st);
    write_reg(CFG_ALPHA, al);
    cfg_write <= 1'b0;
  endtask

  // one input item, with an optional idle burst ahead of it
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $signed($urandom_range(0, 2 ** 20)) - 2 ** 19;
      3:    return S_MAX;
      4:    return S_MIN;
      default: return $signed($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  task automatic load_points(input int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample());
  endtask

  // stop sending and wait until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic signed [SAMPLE_BITS-1:0] extremes [10];
    int pc, st, al, n, k, target;
    extremes = '{S_MAX, S_MIN, S_MAX, S_MIN, 0, -1, 1, S_MAX, 32'sh0001_0000, S_MIN};
    calm       = 1'b0;
    items_sent = 0;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_POINT_COUNT;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    sample_in <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: ten points, 199 steps, extremes mixed with small values
    foreach (extremes[i]) send_sample(extremes[i]);
    drain();

    // three points, longest run, alpha at full scale: saturates downward
    write_reg(CFG_UNUSED, 16'hFFFF);
    program_regs(16'd3, 16'hFFFF, 16'hFFFF);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(S_MIN);
    drain();

    // one step upward into saturation
    program_regs(16'd3, 16'd1, 16'hFFFF);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MAX);
    drain();

    // a count of zero behaves as one point
    program_regs(16'd0, 16'd5, 16'h8000);
    send_sample(32'sh1234_5678);
    drain();

    // two points: no interior, profile comes back unchanged
    program_regs(16'd2, 16'd3, 16'h4000);
    send_sample(S_MIN);
    send_sample(S_MAX);
    drain();

    // count lowered part way through a load: next item completes it
    program_regs(16'd10, 16'd0, 16'd0);
    load_points(4);
    drain();
    write_reg(CFG_POINT_COUNT, 16'd3);
    cfg_write <= 1'b0;
    send_sample(pick_sample());
    drain();

    // random profiles under random settings
    n = 3;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if (items_sent >= target - CALM_ITEMS) calm = 1'b1;
      if (items_sent == 0 || $urandom_range(0, 1) == 0) begin
        k = $urandom_range(0, 15);
        if (k < 10) begin
          pc = $urandom_range(3, 12);  st = $urandom_range(0, 20);
        end else if (k < 12) begin
          pc = $urandom_range(0, 2);   st = $urandom_range(0, 50);
        end else if (k < 13) begin
          pc = $urandom_range(64, 127); st = $urandom_range(0, 3);
        end else if (k < 15) begin
          pc = $urandom_range(3, 6);   st = $urandom_range(100, 400);
        end else begin
          pc = $urandom_range(13, 40); st = $urandom_range(0, 8);
        end
        case ($urandom_range(0, 3))
          0:       al = $urandom_range(0, 65535);
          1:       al = $urandom_range(0, 32768);
          2:       al = ($urandom_range(0, 1) == 0) ? 0 : 65535;
          default: al = $urandom_range(20000, 30000);
        endcase
        drain();
        program_regs(pc[CFG_DATA_BITS-1:0], st[CFG_DATA_BITS-1:0], al[CFG_DATA_BITS-1:0]);
        n = effective_points(pc);
      end
      if (n >= 2 && $urandom_range(0, 7) == 0) begin
        // broken load: change the point count part way through
        k = $urandom_range(1, n - 1);
        load_points(k);
        drain();
        pc = $urandom_range(0, 20);
        write_reg(CFG_POINT_COUNT, pc[CFG_DATA_BITS-1:0]);
        cfg_write <= 1'b0;
        n = effective_points(pc);
        load_points((k >= n) ? 1 : n - k);
      end else begin
        load_points(n);
      end
    end

    // wrap up
    calm = 1'b1;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("explicit_heat_stencil_1d verification clean");
    else
      $display("explicit_heat_stencil_1d verification failed");
    $finish;
  end

endmodule

// File: sim.f
design/ehs_pkg.sv
design/ehs_ram.sv
design/ehs_dp.sv
design/ehs_ctrl.sv
design/explicit_heat_stencil_1d.sv
verif/ehs_profile_checker.sv
verif/testbench.sv
